@@ hw/rtl/oate_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oate_pkg
// Shared types and constants for the ordered array table engine: command and
// status codes, the request and response words, and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package oate_pkg;

    localparam int DEPTH_DEF = 256;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_PREPEND = 3'd2,
        CMD_POP     = 3'd3,
        CMD_DELETE  = 3'd4,
        CMD_REMOVE  = 3'd5,
        CMD_FIND    = 3'd6,
        CMD_READ    = 3'd7
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] item_value;
        logic [8:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [8:0]         removed_count;
        logic [8:0]         fill_count;
        logic               is_empty;
        logic [2:0]         status;
    } t_rsp;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SHR,
        OP_PUT,
        OP_SHL,
        OP_DEC,
        OP_POP,
        OP_COMPACT,
        OP_SETCNT,
        OP_FIND,
        OP_RDPOS,
        OP_RESP
    } t_dp_op;

    typedef enum logic [1:0] {
        RV_ZERO,
        RV_DATA,
        RV_MAX
    } t_rv_sel;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
        t_rv_sel rv_sel;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd_code cmd;
        logic      ins_range;
        logic      del_range;
        logic      full;
        logic      empty;
        logic      shr_done;
        logic      fwd_done;
        logic      hit;
        logic      none_removed;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ hw/rtl/oate_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oate_dpath
// Entry memory, fill count and walk pointers. Performs one operation per
// cycle as commanded by the controller and reports status flags.
// ----------------------------------------------------------------------------
module oate_dpath
    import oate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_req     i_req,
    input  wire t_dp_ctl  i_ctl,
    output t_dp_stat      o_stat,
    output t_rsp          o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    logic [31:0]   mem [DEPTH];

    logic [XW-1:0] r_count;
    logic [XW-1:0] r_idx;
    logic [XW-1:0] r_pos;
    logic [XW-1:0] r_w;
    logic [XW-1:0] r_wa;
    logic [XW-1:0] r_fpos;
    logic [XW-1:0] r_removed;
    logic [31:0]   r_val;
    logic [31:0]   r_rd_data;
    t_cmd_code     r_cmd;
    logic          r_pend;
    logic          r_hit;
    t_rsp          r_rsp;

    logic [XW-1:0] idx_m1;
    logic [XW-1:0] cnt_m1;
    logic [XW-1:0] pos_x;
    logic          issue;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          keep;
    logic          match;

    assign idx_m1 = r_idx - XW'(1);
    assign cnt_m1 = r_count - XW'(1);
    assign pos_x  = XW'(i_req.position);
    assign keep   = r_pend && (r_rd_data != r_val);
    assign match  = r_pend && !r_hit && (r_rd_data == r_val);

    always_comb begin
        issue   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_wa[AW-1:0];
        wr_data = r_rd_data;
        case (i_ctl.op)
            OP_SHR: begin
                issue   = r_idx > r_pos;
                rd_en   = issue;
                rd_addr = idx_m1[AW-1:0];
                wr_en   = r_pend;
            end
            OP_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_data = r_val;
            end
            OP_SHL: begin
                issue = r_idx < r_count;
                rd_en = issue;
                wr_en = r_pend;
            end
            OP_POP: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
            end
            OP_COMPACT: begin
                issue   = r_idx < r_count;
                rd_en   = issue;
                wr_en   = keep;
                wr_addr = r_w[AW-1:0];
            end
            OP_FIND: begin
                issue = (r_idx < r_count) && !r_hit;
                rd_en = issue;
            end
            OP_RDPOS: begin
                rd_en   = 1'b1;
                rd_addr = r_pos[AW-1:0];
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            case (i_ctl.op) inside
                OP_LOAD: begin
                    r_cmd     <= t_cmd_code'(i_req.cmd);
                    r_val     <= i_req.item_value;
                    r_w       <= '0;
                    r_pend    <= 1'b0;
                    r_hit     <= 1'b0;
                    r_fpos    <= '0;
                    r_removed <= '0;
                    case (i_req.cmd)
                        CMD_PUSH:    r_pos <= r_count;
                        CMD_PREPEND: r_pos <= '0;
                        default:     r_pos <= pos_x;
                    endcase
                    case (i_req.cmd) inside
                        CMD_PUSH, CMD_INSERT, CMD_PREPEND: r_idx <= r_count;
                        CMD_DELETE:                        r_idx <= pos_x + XW'(1);
                        default:                           r_idx <= '0;
                    endcase
                end
                OP_SHR: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= idx_m1;
                        r_wa  <= r_idx;
                    end
                end
                OP_PUT: begin
                    r_count <= r_count + XW'(1);
                end
                OP_SHL: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= r_idx + XW'(1);
                        r_wa  <= idx_m1;
                    end
                end
                OP_DEC, OP_POP: begin
                    r_count <= cnt_m1;
                end
                OP_COMPACT: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= r_idx + XW'(1);
                    end
                    if (keep) begin
                        r_w <= r_w + XW'(1);
                    end
                end
                OP_SETCNT: begin
                    r_count   <= r_w;
                    r_removed <= r_count - r_w;
                end
                OP_FIND: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= r_idx + XW'(1);
                        r_wa  <= r_idx;
                    end
                    if (match) begin
                        r_hit  <= 1'b1;
                        r_fpos <= r_wa;
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_RESP) begin
            case (i_ctl.rv_sel)
                RV_DATA: r_rsp.read_value <= r_rd_data;
                RV_MAX:  r_rsp.read_value <= INT_MAX;
                default: r_rsp.read_value <= '0;
            endcase
            r_rsp.found_position <= r_fpos[7:0];
            r_rsp.removed_count  <= r_removed[8:0];
            r_rsp.fill_count     <= r_count[8:0];
            r_rsp.is_empty       <= (r_count == '0);
            r_rsp.status         <= i_ctl.status;
        end
    end

    assign o_rsp = r_rsp;

    always_comb begin
        o_stat.cmd          = r_cmd;
        o_stat.ins_range    = r_pos > r_count;
        o_stat.del_range    = r_pos >= r_count;
        o_stat.full         = r_count >= XW'(DEPTH);
        o_stat.empty        = (r_count == '0);
        o_stat.shr_done     = (r_idx == r_pos) && !r_pend;
        o_stat.fwd_done     = (r_idx >= r_count) && !r_pend;
        o_stat.hit          = r_hit;
        o_stat.none_removed = (r_w == r_count);
    end

endmodule
`default_nettype wire

@@ hw/rtl/oate_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oate_ctrl
// Command sequencer: checks each command but remove and find against the fill
// count, steps the datapath through its walk and issues the response strobe.
// ----------------------------------------------------------------------------
module oate_ctrl
    import oate_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_dp_stat i_stat,
    output logic          busy,
    output logic          o_done,
    output t_dp_ctl       o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHR,
        S_PUT,
        S_SHL,
        S_DEC,
        S_POP,
        S_COMPACT,
        S_SETCNT,
        S_FIND,
        S_RDPOS,
        S_RESP
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_rv_sel r_rv_sel, n_rv_sel;
    logic    r_done, n_done;

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_rv_sel     = r_rv_sel;
        n_done       = 1'b0;
        o_ctl.op     = OP_IDLE;
        o_ctl.status = r_status;
        o_ctl.rv_sel = r_rv_sel;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.op = OP_LOAD;
                    n_state  = S_DECODE;
                    n_status = ST_OK;
                    n_rv_sel = RV_ZERO;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd) inside
                    CMD_PUSH, CMD_PREPEND: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_SHR;
                        end
                    end
                    CMD_INSERT: begin
                        if (i_stat.ins_range) begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_SHR;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                            n_rv_sel = RV_MAX;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.del_range) begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_SHL;
                        end
                    end
                    CMD_REMOVE: begin
                        n_state = S_COMPACT;
                    end
                    CMD_FIND: begin
                        n_state = S_FIND;
                    end
                    CMD_READ: begin
                        if (i_stat.del_range) begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_RDPOS;
                        end
                    end
                endcase
            end
            S_SHR: begin
                o_ctl.op = OP_SHR;
                if (i_stat.shr_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_ctl.op = OP_PUT;
                n_state  = S_RESP;
            end
            S_SHL: begin
                o_ctl.op = OP_SHL;
                if (i_stat.fwd_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_ctl.op = OP_DEC;
                n_state  = S_RESP;
            end
            S_POP: begin
                o_ctl.op = OP_POP;
                n_rv_sel = RV_DATA;
                n_state  = S_RESP;
            end
            S_COMPACT: begin
                o_ctl.op = OP_COMPACT;
                if (i_stat.fwd_done) begin
                    n_state = S_SETCNT;
                end
            end
            S_SETCNT: begin
                o_ctl.op = OP_SETCNT;
                n_status = i_stat.none_removed ? ST_NOT_FOUND : ST_OK;
                n_state  = S_RESP;
            end
            S_FIND: begin
                o_ctl.op = OP_FIND;
                if (i_stat.hit) begin
                    n_state = S_RESP;
                end else if (i_stat.fwd_done) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end
            end
            S_RDPOS: begin
                o_ctl.op = OP_RDPOS;
                n_rv_sel = RV_DATA;
                n_state  = S_RESP;
            end
            S_RESP: begin
                o_ctl.op = OP_RESP;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_rv_sel <= RV_ZERO;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_rv_sel <= n_rv_sel;
            r_done   <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule
`default_nettype wire

@@ hw/rtl/ordered_array_table_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// Fixed-capacity ordered array of signed 32-bit entries with a fill count.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the response is produced, and o_done marks the response word on
// o_rsp for exactly one cycle with no way to hold it off. Push, pop and read
// move no entries. Insert, prepend, delete, remove-all and find walk the
// entries through the entry memory, at most one read and one write per cycle,
// moving or examining one entry per cycle, so their response waits on the
// number of entries moved or examined. Error cases (full, empty, index out of
// range) change nothing. The entry memory is not cleared at reset; only
// entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module ordered_array_table_engine
    import oate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    oate_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    oate_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

@@ hw/rtl/oate_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oate_checker
// Port-level checks on the command and response sequencing of the engine.
// ----------------------------------------------------------------------------
module oate_checker
    import oate_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire t_req i_req,
    input wire logic busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    // an accepted word keeps the engine busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a word");

    // a response only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("response without a preceding busy cycle");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("response strobe longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.fill_count != 9'd0)) |-> !o_rsp.is_empty)
        else $error("empty flag set with nonzero fill count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_FULL)) |-> (o_rsp.fill_count == 9'(DEPTH)))
        else $error("full status with fill count below capacity");

endmodule

bind ordered_array_table_engine oate_checker #(.DEPTH(DEPTH)) u_oate_checker (.*);
`default_nettype wire
